// File: rtl/sas_pkg.sv
// Shared types and constants of the slotted ALOHA slot resolver.
`timescale 1ns / 1ps

package sas_pkg;

  localparam int unsigned DRAW_W     = 16;
  localparam int unsigned SLOT_W     = 32;
  localparam int unsigned WINNER_W   = 7;
  localparam int unsigned BACKLOG_W  = 8;
  localparam int unsigned USERS_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USERS   = 2'd2;

  localparam logic [DRAW_W-1:0]  ARRIVAL_RST = 16'd262;
  localparam logic [DRAW_W-1:0]  RETRY_RST   = 16'd2621;
  localparam logic [USERS_W-1:0] USERS_RST   = 8'd100;

  // One entry of the per-user table.
  typedef struct packed {
    logic              backlogged;
    logic [SLOT_W-1:0] first_slot;
  } user_entry_t;

  // One slot result.
  typedef struct packed {
    logic                 success;
    logic                 collision;
    logic [WINNER_W-1:0]  winner;
    logic [SLOT_W-1:0]    delay;
    logic [BACKLOG_W-1:0] backlog;
    logic [SLOT_W-1:0]    delivered_total;
    logic [SLOT_W-1:0]    slot_index;
  } result_t;

endpackage

// File: rtl/sas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/sas_result_fifo.sv
// Two-entry result queue between the slot pipeline and the output channel.
`timescale 1ns / 1ps

module sas_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sas_pkg::result_t  data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sas_pkg::result_t  data_o,
  output logic [1:0]        level_o,
  output logic              pop_o
);

  sas_pkg::result_t entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign out_valid_o = (count_q != 2'd0);
  assign pop_o       = out_valid_o && !out_stall_i;
  assign data_o      = entry_q[rd_ptr_q];
  assign level_o     = count_q;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_o ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/slotted_aloha_slot_resolver.sv
// Top level of the slotted ALOHA slot resolver: user pipeline, table and result queue.
`timescale 1ns / 1ps

// The block runs a slotted ALOHA channel one user at a time: each transfer on
// the input carries the 16-bit draw of the next user, users 0 to
// active_users-1 make up one slot, and the transfer of the last user of a
// slot yields one result transfer (success, collision, winner, delay,
// backlog, delivered total and slot index). Draws are taken at one per clock
// cycle while the input is not stalled; a result is formed in the write-back
// stage and waits in a two-entry queue, so the input keeps flowing while the
// output is stalled for a short while. Per-user state (backlogged flag and
// slot of the first attempt) lives in one RAM with a registered read; a draw
// reads its entry when accepted and writes it back in the next cycle, and
// the last write is forwarded to a read of the same entry. The success of a
// slot clears the winner's flag lazily: the clear is held in a register and
// folded into that user's next write-back, or written in any cycle in which
// the write port is free. A last draw of a slot waits in the rare case that
// such a clear is still outstanding, or about to be set, and cannot be
// folded in, and for as long as the result queue is full. After reset the
// block sweeps every entry of the table to mark all users silent and takes
// no draw in that time; configuration writes are taken at any time.

module slotted_aloha_slot_resolver #(
  parameter int unsigned MAX_USERS = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration
  input  logic                             cfg_we_i,
  input  logic [sas_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sas_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Draw channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sas_pkg::DRAW_W-1:0]       draw_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             success_o,
  output logic                             collision_o,
  output logic [sas_pkg::WINNER_W-1:0]     winner_o,
  output logic [sas_pkg::SLOT_W-1:0]       delay_o,
  output logic [sas_pkg::BACKLOG_W-1:0]    backlog_o,
  output logic [sas_pkg::SLOT_W-1:0]       delivered_total_o,
  output logic [sas_pkg::SLOT_W-1:0]       slot_index_o
);

  localparam int unsigned AW = $clog2(MAX_USERS);
  // Width wide enough for both the user count register and MAX_USERS.
  localparam int unsigned CW = AW + 9;
  localparam int unsigned BW = $clog2(MAX_USERS + 1);
  localparam int unsigned EW = $bits(sas_pkg::user_entry_t);

  // Saturating attempt counter values.
  localparam logic [1:0] ATT_NONE = 2'd0;
  localparam logic [1:0] ATT_ONE  = 2'd1;
  localparam logic [1:0] ATT_MANY = 2'd2;

  // Configuration registers.
  logic [sas_pkg::DRAW_W-1:0]  arr_thr_q;
  logic [sas_pkg::DRAW_W-1:0]  ret_thr_q;
  logic [sas_pkg::USERS_W-1:0] act_users_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_thr_q   <= sas_pkg::ARRIVAL_RST;
      ret_thr_q   <= sas_pkg::RETRY_RST;
      act_users_q <= sas_pkg::USERS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sas_pkg::REG_ARRIVAL: arr_thr_q   <= cfg_data_i;
        sas_pkg::REG_RETRY:   ret_thr_q   <= cfg_data_i;
        sas_pkg::REG_USERS:   act_users_q <= cfg_data_i[sas_pkg::USERS_W-1:0];
        default: ;
      endcase
    end
  end

  // Table clearing sweep after reset.
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // Accept stage (read issued) and slot position.
  logic          s1_valid_q, s1_valid_d;
  logic          s1_end_q, s1_end_d;
  logic [AW-1:0] s1_user_q, s1_user_d;
  logic [sas_pkg::DRAW_W-1:0] s1_draw_q, s1_draw_d;
  logic [AW-1:0] pos_q, pos_d;

  // Per-slot state.
  logic [sas_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [1:0]                 att_q, att_d;
  logic [AW-1:0]              cand_q, cand_d;
  logic [sas_pkg::SLOT_W-1:0] cand_delay_q, cand_delay_d;
  logic [BW-1:0]              backlog_q, backlog_d;
  logic [sas_pkg::SLOT_W-1:0] delivered_q, delivered_d;

  // Outstanding clear of the last winner's backlogged flag.
  logic          pc_valid_q, pc_valid_d;
  logic [AW-1:0] pc_user_q, pc_user_d;

  // Forwarding of the write made in the previous cycle.
  logic                  fwd_valid_q, fwd_valid_d;
  logic [AW-1:0]         fwd_addr_q, fwd_addr_d;
  sas_pkg::user_entry_t  fwd_data_q, fwd_data_d;

  // RAM port signals.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  sas_pkg::user_entry_t ram_wentry;
  logic [EW-1:0]        ram_rdata;
  sas_pkg::user_entry_t ram_rentry;

  // Result queue.
  sas_pkg::result_t res;
  sas_pkg::result_t res_out;
  logic             res_push;
  logic [1:0]       q_level;
  logic             q_pop;

  // Effective user count and end-of-slot detection for the draw on offer.
  logic [CW-1:0] users_w;
  logic [CW-1:0] n_eff;
  logic          in_end;
  logic          in_accept;
  logic          stall_pc;
  logic          stall_chain;
  logic          stall_out;
  logic [2:0]    q_occ;

  always_comb begin
    users_w = {{(CW - sas_pkg::USERS_W){1'b0}}, act_users_q};
    if (users_w == '0) begin
      n_eff = CW'(1);
    end else if (users_w > CW'(MAX_USERS)) begin
      n_eff = CW'(MAX_USERS);
    end else begin
      n_eff = users_w;
    end
    in_end = ({{(CW - AW){1'b0}}, pos_q} + CW'(1)) >= n_eff;
  end

  // A last draw must not reach the write-back stage while an older clear is
  // still outstanding and that draw cannot absorb it. The outstanding clear
  // is either registered already or about to be set by the draw ahead.
  assign stall_pc = in_end && pc_valid_q && (pos_q != pc_user_q)
                    && !(s1_valid_q && (s1_user_q == pc_user_q));
  assign stall_chain = in_end && s1_valid_q && s1_end_q
                       && (((att_q == ATT_NONE) && (pos_q != s1_user_q))
                           || ((att_q == ATT_ONE) && (pos_q != cand_q)));
  // Room for the result of a last draw in the queue.
  assign q_occ     = {1'b0, q_level} + {2'b0, s1_valid_q && s1_end_q} - {2'b0, q_pop};
  assign stall_out = in_end && (q_occ >= 3'd2);

  assign in_stall_o = clr_busy_q || stall_pc || stall_chain || stall_out;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Write-back stage.
  sas_pkg::user_entry_t ent;
  logic                 fwd_hit;
  logic                 pc_hit;
  logic                 bl_old;
  logic                 bl_new;
  logic                 attempts;
  logic [sas_pkg::SLOT_W-1:0] fas_new;
  logic                 item_wr;
  logic                 free_commit;
  logic                 pc_commit;
  logic [1:0]           att_next;
  logic [AW-1:0]        cand_next;
  logic [sas_pkg::SLOT_W-1:0] cand_delay_next;
  logic [BW-1:0]        backlog_next;
  logic                 res_success;
  logic [AW+sas_pkg::WINNER_W-1:0]  winner_wide;
  logic [BW+sas_pkg::BACKLOG_W-1:0] backlog_wide;

  assign ram_rentry = sas_pkg::user_entry_t'(ram_rdata);

  always_comb begin
    fwd_hit  = fwd_valid_q && (fwd_addr_q == s1_user_q);
    ent      = fwd_hit ? fwd_data_q : ram_rentry;
    pc_hit   = pc_valid_q && (pc_user_q == s1_user_q);
    bl_old   = ent.backlogged && !pc_hit;
    attempts = bl_old ? (s1_draw_q <= ret_thr_q) : (s1_draw_q <= arr_thr_q);
    bl_new   = bl_old || attempts;
    fas_new  = (attempts && !bl_old) ? slot_q : ent.first_slot;

    item_wr     = s1_valid_q && (attempts || pc_hit);
    free_commit = pc_valid_q && !item_wr && !clr_busy_q;
    pc_commit   = (item_wr && pc_hit) || free_commit;

    if (attempts) begin
      att_next        = (att_q == ATT_MANY) ? ATT_MANY : att_q + 2'd1;
      cand_next       = s1_user_q;
      cand_delay_next = slot_q - fas_new;
    end else begin
      att_next        = att_q;
      cand_next       = cand_q;
      cand_delay_next = cand_delay_q;
    end
    backlog_next = backlog_q + {{(BW - 1){1'b0}}, bl_new};
    res_success  = (att_next == ATT_ONE);
    res_push     = s1_valid_q && s1_end_q;

    winner_wide  = {{sas_pkg::WINNER_W{1'b0}}, cand_next};
    backlog_wide = {{sas_pkg::BACKLOG_W{1'b0}}, backlog_next};

    res.success         = res_success;
    res.collision       = (att_next == ATT_MANY);
    res.winner          = res_success ? winner_wide[sas_pkg::WINNER_W-1:0] : '0;
    res.delay           = res_success ? cand_delay_next : '0;
    res.backlog         = backlog_wide[sas_pkg::BACKLOG_W-1:0];
    res.delivered_total = delivered_q + {{(sas_pkg::SLOT_W - 1){1'b0}}, res_success};
    res.slot_index      = slot_q;
  end

  // Write port: the clearing sweep, then an item write-back, then a pending
  // clear of the last winner when the port is otherwise free.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = s1_user_q;
    ram_wentry = '0;
    priority if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
    end else if (item_wr) begin
      ram_we                = 1'b1;
      ram_waddr             = s1_user_q;
      ram_wentry.backlogged = bl_new;
      ram_wentry.first_slot = fas_new;
    end else if (free_commit) begin
      ram_we    = 1'b1;
      ram_waddr = pc_user_q;
    end
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MAX_USERS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end

    s1_valid_d = in_accept;
    s1_end_d   = in_end;
    s1_user_d  = pos_q;
    s1_draw_d  = in_accept ? draw_i : s1_draw_q;
    pos_d      = pos_q;
    if (in_accept) begin
      pos_d = in_end ? '0 : pos_q + AW'(1);
    end

    slot_d       = slot_q;
    att_d        = att_q;
    cand_d       = cand_q;
    cand_delay_d = cand_delay_q;
    backlog_d    = backlog_q;
    delivered_d  = delivered_q;
    if (s1_valid_q) begin
      if (s1_end_q) begin
        slot_d       = slot_q + 32'd1;
        att_d        = ATT_NONE;
        cand_d       = '0;
        cand_delay_d = '0;
        backlog_d    = '0;
        delivered_d  = res.delivered_total;
      end else begin
        att_d        = att_next;
        cand_d       = cand_next;
        cand_delay_d = cand_delay_next;
        backlog_d    = backlog_next;
      end
    end

    pc_valid_d = pc_valid_q;
    pc_user_d  = pc_user_q;
    if (res_push && res_success) begin
      pc_valid_d = 1'b1;
      pc_user_d  = cand_next;
    end else if (pc_commit) begin
      pc_valid_d = 1'b0;
    end

    fwd_valid_d = ram_we;
    fwd_addr_d  = ram_waddr;
    fwd_data_d  = ram_wentry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q   <= 1'b1;
      clr_addr_q   <= '0;
      s1_valid_q   <= 1'b0;
      s1_end_q     <= 1'b0;
      s1_user_q    <= '0;
      pos_q        <= '0;
      slot_q       <= '0;
      att_q        <= ATT_NONE;
      cand_q       <= '0;
      cand_delay_q <= '0;
      backlog_q    <= '0;
      delivered_q  <= '0;
      pc_valid_q   <= 1'b0;
      pc_user_q    <= '0;
      fwd_valid_q  <= 1'b0;
      fwd_addr_q   <= '0;
    end else begin
      clr_busy_q   <= clr_busy_d;
      clr_addr_q   <= clr_addr_d;
      s1_valid_q   <= s1_valid_d;
      s1_end_q     <= s1_end_d;
      s1_user_q    <= s1_user_d;
      pos_q        <= pos_d;
      slot_q       <= slot_d;
      att_q        <= att_d;
      cand_q       <= cand_d;
      cand_delay_q <= cand_delay_d;
      backlog_q    <= backlog_d;
      delivered_q  <= delivered_d;
      pc_valid_q   <= pc_valid_d;
      pc_user_q    <= pc_user_d;
      fwd_valid_q  <= fwd_valid_d;
      fwd_addr_q   <= fwd_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_draw_q  <= s1_draw_d;
    fwd_data_q <= fwd_data_d;
  end

  sas_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_USERS)
  ) u_user_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  sas_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .data_i      (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (res_out),
    .level_o     (q_level),
    .pop_o       (q_pop)
  );

  assign success_o         = res_out.success;
  assign collision_o       = res_out.collision;
  assign winner_o          = res_out.winner;
  assign delay_o           = res_out.delay;
  assign backlog_o         = res_out.backlog;
  assign delivered_total_o = res_out.delivered_total;
  assign slot_index_o      = res_out.slot_index;

`ifndef ASSERT_OFF
  // No draw is taken while the table is being swept.
  a_no_draw_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (in_stall_o && !s1_valid_q))
    else $error("draw taken during table sweep");

  // A new winner never overwrites a clear that has not reached the table.
  a_clear_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_success) |-> (!pc_valid_q || pc_commit))
    else $error("pending winner clear lost");

  // A result always finds room in the queue.
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> ((q_level != 2'd2) || q_pop))
    else $error("result queue overflow");

  // A last draw that is taken produces its result in the following cycle.
  a_end_reaches_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_end) |=> res_push)
    else $error("last draw of slot did not reach write-back");
`endif

endmodule

// File: verif/tb_slotted_aloha_slot_resolver.sv
// Self-checking testbench for the slotted ALOHA slot resolver, with directed and random draws.
`timescale 1ns / 1ps

// The testbench feeds the resolver one draw per user and checks the result of
// every slot. A model of the channel runs alongside the block. It keeps its own
// copy of the per-user table (backlogged flag and slot of the first attempt),
// the slot, position and attempt counters and the three registers. At every
// accepted draw transfer the model steps one user. When the step closes a slot,
// the result that the block must give is queued. Every result transfer is
// compared field by field with the oldest queued result.
//
// The run opens with a short directed table. It covers the register extremes,
// a threshold hit exactly, retries, collisions with more than two attempters,
// a user count of zero and a count cut down in the middle of a slot. Where a
// row's result is plain from the rules, it is typed into the table. Random
// phases follow, each with its own idling mode and mostly fresh registers.

module tb_slotted_aloha_slot_resolver;
  import sas_pkg::*;

  localparam int unsigned USERS_MAX     = 128;
  localparam int unsigned RESET_CYCLES  = 7;
  // Covers the write-back stage and the two-entry result queue, with margin.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_DRAWS  = 1900;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  typedef enum logic {ROW_CFG, ROW_DRAW} row_kind_e;

  // One row of the directed table: a register write or a draw. A draw row
  // may carry the result that it must produce.
  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   val;
    logic                    typed;
    result_t                 res;
  } dir_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [DRAW_W-1:0]      draw_i      = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   success_o;
  logic                   collision_o;
  logic [WINNER_W-1:0]    winner_o;
  logic [SLOT_W-1:0]      delay_o;
  logic [BACKLOG_W-1:0]   backlog_o;
  logic [SLOT_W-1:0]      delivered_total_o;
  logic [SLOT_W-1:0]      slot_index_o;

  // Channel model: registers and per-user state.
  logic [DRAW_W-1:0]   m_arrival = ARRIVAL_RST;
  logic [DRAW_W-1:0]   m_retry   = RETRY_RST;
  logic [USERS_W-1:0]  m_users   = USERS_RST;
  bit                  backlogged [USERS_MAX];
  logic [SLOT_W-1:0]   first_slot [USERS_MAX];
  logic [SLOT_W-1:0]   slot_no      = '0;
  logic [SLOT_W-1:0]   delivered_no = '0;
  logic [SLOT_W-1:0]   cand_delay   = '0;
  int unsigned         user_pos     = 0;
  int unsigned         cand_user    = 0;
  int unsigned         tries        = 0;
  int unsigned         backlog_no   = 0;

  // Slot results still owed by the block, oldest first.
  result_t             pending_slots [$];
  dir_row_t            dir_rows [$];
  result_t             want;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned fail_cnt       = 0;
  int unsigned draws_sent     = 0;
  int unsigned slots_seen     = 0;
  int unsigned wins_seen      = 0;
  int unsigned clashes_seen   = 0;
  int unsigned cfg_writes     = 0;

  slotted_aloha_slot_resolver #(
    .MAX_USERS (USERS_MAX)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .draw_i            (draw_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .success_o         (success_o),
    .collision_o       (collision_o),
    .winner_o          (winner_o),
    .delay_o           (delay_o),
    .backlog_o         (backlog_o),
    .delivered_total_o (delivered_total_o),
    .slot_index_o      (slot_index_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Users start silent, as the clearing sweep after reset leaves them.
  initial begin
    foreach (backlogged[i]) begin
      backlogged[i] = 1'b0;
      first_slot[i] = '0;
    end
  end

  // Hard stop, far beyond the slowest correct run of this stimulus.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // A count of zero behaves as one user and anything above the table size as
  // the full table.
  function automatic int unsigned eff_users();
    if (m_users == 0) return 1;
    if (m_users > USERS_MAX) return USERS_MAX;
    return m_users;
  endfunction

  // Steps one user through its draw. When that user is the last of the slot,
  // the slot is resolved and its result is handed back.
  task automatic resolve_draw(input logic [DRAW_W-1:0] value, output bit done,
                              output result_t res);
    int unsigned n;
    int unsigned u;
    bit          attempts;
    n    = eff_users();
    u    = (user_pos >= USERS_MAX) ? USERS_MAX - 1 : user_pos;
    done = 1'b0;
    res  = '0;
    if (!backlogged[u]) begin
      attempts = value <= m_arrival;
      if (attempts) first_slot[u] = slot_no;
    end else begin
      attempts = value <= m_retry;
    end
    if (attempts) begin
      backlogged[u] = 1'b1;
      if (tries < 2) tries++;
      cand_user  = u;
      cand_delay = slot_no - first_slot[u];
    end
    if (backlogged[u]) backlog_no++;
    // A count cut down in mid slot ends the slot at the next draw.
    if (u + 1 < n) begin
      user_pos = u + 1;
      return;
    end
    done          = 1'b1;
    res.success   = (tries == 1);
    res.collision = (tries >= 2);
    if (res.success) begin
      backlogged[cand_user] = 1'b0;
      delivered_no++;
      res.winner = cand_user[WINNER_W-1:0];
      res.delay  = cand_delay;
    end
    res.backlog         = backlog_no[BACKLOG_W-1:0];
    res.delivered_total = delivered_no;
    res.slot_index      = slot_no;
    slot_no++;
    user_pos   = 0;
    tries      = 0;
    cand_user  = 0;
    cand_delay = '0;
    backlog_no = 0;
  endtask

  task automatic check_field(input string name, input logic [SLOT_W-1:0] exp_val,
                             input logic [SLOT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  // Result side: checks each transfer and stalls at the rate of the phase.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_slots.size() == 0) begin
        $error("Result transfer for slot %0d arrived with none owed", slot_index_o);
        fail_cnt++;
      end else begin
        want = pending_slots.pop_front();
        check_field("success", want.success, success_o);
        check_field("collision", want.collision, collision_o);
        check_field("winner", want.winner, winner_o);
        check_field("delay", want.delay, delay_o);
        check_field("backlog", want.backlog, backlog_o);
        check_field("delivered_total", want.delivered_total, delivered_total_o);
        check_field("slot_index", want.slot_index, slot_index_o);
        slots_seen++;
        if (success_o === 1'b1) wins_seen++;
        if (collision_o === 1'b1) clashes_seen++;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one draw after a random gap and holds it until the transfer. The
  // model steps at the edge of the transfer. A typed row replaces the model's
  // result with the one written in the table.
  task automatic send_draw(input logic [DRAW_W-1:0] value, input bit typed,
                           input result_t typed_res);
    bit      done;
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    draw_i     <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    resolve_draw(value, done, res);
    draws_sent++;
    if (typed) pending_slots.push_back(typed_res);
    else if (done) pending_slots.push_back(res);
  endtask

  // Lets every owed result arrive. The settle time also covers a slot left
  // open, which owes nothing but may still be in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_slots.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      REG_ARRIVAL: m_arrival = val;
      REG_RETRY:   m_retry   = val;
      REG_USERS:   m_users   = val[USERS_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic dir_row_t draw_row(logic [DRAW_W-1:0] val);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_DRAW;
    r.val  = val;
    return r;
  endfunction

  function automatic dir_row_t chk_row(logic [DRAW_W-1:0] val, bit s, bit c,
                                       logic [WINNER_W-1:0] w, logic [SLOT_W-1:0] d,
                                       logic [BACKLOG_W-1:0] b,
                                       logic [SLOT_W-1:0] dt, logic [SLOT_W-1:0] si);
    dir_row_t r;
    r                     = draw_row(val);
    r.typed               = 1'b1;
    r.res.success         = s;
    r.res.collision       = c;
    r.res.winner          = w;
    r.res.delay           = d;
    r.res.backlog         = b;
    r.res.delivered_total = dt;
    r.res.slot_index      = si;
    return r;
  endfunction

  // Most draws are uniform. The rest sit at or next to a threshold or at
  // the ends of the range.
  function automatic logic [DRAW_W-1:0] pick_draw();
    int unsigned       sel;
    logic [DRAW_W-1:0] base;
    sel = $urandom_range(19);
    if (sel < 13) return DRAW_W'($urandom_range(65535));
    if (sel < 17) begin
      base = ($urandom_range(1) == 1) ? m_arrival : m_retry;
      return base + DRAW_W'($urandom_range(2)) - DRAW_W'(1);
    end
    return sel[0] ? {DRAW_W{1'b1}} : {DRAW_W{1'b0}};
  endfunction

  // A threshold for n users. It is either an extreme, any value, or one that
  // gives about one attempt per slot, so that successes, collisions and empty
  // slots all turn up.
  function automatic logic [CFG_DATA_W-1:0] pick_threshold(int unsigned n);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return {CFG_DATA_W{1'b1}};
    if (sel == 2) return CFG_DATA_W'($urandom_range(65535));
    return CFG_DATA_W'($urandom_range(2 * 65535 / n));
  endfunction

  // Small counts mostly. Now and then the count is zero, one, the full table,
  // or at or above it with junk in the upper data bits.
  function automatic logic [CFG_DATA_W-1:0] pick_users();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel <= 9)  return CFG_DATA_W'($urandom_range(1, 8));
    if (sel <= 11) return CFG_DATA_W'($urandom_range(9, 40));
    if (sel == 12) return '0;
    if (sel == 13) return CFG_DATA_W'(1);
    if (sel == 14) return CFG_DATA_W'(USERS_MAX);
    return CFG_DATA_W'(($urandom_range(255) << 8) | $urandom_range(USERS_MAX, 255));
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned count;
    int unsigned dir_draws;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-user slots first: success at zero, silence at full scale, and
    // the arrival threshold hit exactly and just missed. Two users then
    // collide and retry one at a time, with delays of one and two slots.
    // A count of zero acts as one. With every new packet attempting, three
    // users collide while the count is cut to one in mid slot. A retry
    // threshold of zero then lets only a zero draw retry. The last write puts
    // junk in the upper data bits of the count.
    dir_rows.push_back(cfg_row(REG_USERS, 16'd1));
    dir_rows.push_back(chk_row(16'h0000, 1, 0, 0, 0, 1, 1, 0));
    dir_rows.push_back(chk_row(16'hFFFF, 0, 0, 0, 0, 0, 1, 1));
    dir_rows.push_back(chk_row(16'd262,  1, 0, 0, 0, 1, 2, 2));
    dir_rows.push_back(chk_row(16'd263,  0, 0, 0, 0, 0, 2, 3));
    dir_rows.push_back(cfg_row(REG_USERS, 16'd2));
    dir_rows.push_back(draw_row(16'h0000));
    dir_rows.push_back(chk_row(16'h0000, 0, 1, 0, 0, 2, 2, 4));
    dir_rows.push_back(draw_row(16'd2621));
    dir_rows.push_back(chk_row(16'd2622, 1, 0, 0, 1, 2, 3, 5));
    dir_rows.push_back(draw_row(16'hFFFF));
    dir_rows.push_back(chk_row(16'h0000, 1, 0, 1, 2, 1, 4, 6));
    dir_rows.push_back(cfg_row(REG_USERS, 16'd0));
    dir_rows.push_back(chk_row(16'h0000, 1, 0, 0, 0, 1, 5, 7));
    dir_rows.push_back(cfg_row(REG_ARRIVAL, 16'hFFFF));
    dir_rows.push_back(cfg_row(REG_RETRY, 16'h0000));
    dir_rows.push_back(cfg_row(REG_USERS, 16'd3));
    dir_rows.push_back(draw_row(16'hFFFF));
    dir_rows.push_back(draw_row(16'h8000));
    dir_rows.push_back(cfg_row(REG_USERS, 16'd1));
    dir_rows.push_back(chk_row(16'h1234, 0, 1, 0, 0, 3, 5, 8));
    dir_rows.push_back(chk_row(16'h0001, 0, 0, 0, 0, 1, 5, 9));
    dir_rows.push_back(chk_row(16'h0000, 1, 0, 0, 2, 1, 6, 10));
    dir_rows.push_back(cfg_row(REG_USERS, 16'hFF03));
    dir_rows.push_back(draw_row(16'h0000));
    dir_rows.push_back(draw_row(16'h0000));
    dir_rows.push_back(draw_row(16'h0005));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else send_draw(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
    end
    dir_draws = draws_sent;

    // Random phases. The idling mode rotates: none, an idle sender, a
    // stalling receiver, then light idling on both sides. A phase may end in
    // mid slot, so that the next count write can land there.
    phase = 0;
    while (draws_sent < dir_draws + RANDOM_DRAWS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if ($urandom_range(3) != 0) write_reg(REG_USERS, pick_users());
      n = eff_users();
      if ($urandom_range(3) != 0) write_reg(REG_ARRIVAL, pick_threshold(n));
      if ($urandom_range(3) != 0) write_reg(REG_RETRY, pick_threshold(n));
      count = (n >= 100) ? 2 * n : 120;
      repeat (count) send_draw(pick_draw(), 1'b0, '0);
      phase++;
    end

    wait_idle();
    $display("Ran %0d draws over %0d phases with %0d register writes.",
             draws_sent, phase, cfg_writes);
    $display("Checked %0d slot results: %0d successes, %0d collisions.",
             slots_seen, wins_seen, clashes_seen);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
